// ===== rtl/core/otrk_pkg.sv =====
// Shared types and constants for the orientation zero / unwrap tracker.
// Used by otrk_axis and orientation_zero_unwrap_tracker_top; no dependencies.
`default_nettype none
package otrk_pkg;

  localparam int ANG_W = 16;
  localparam int TOT_W = 32;
  localparam int CFG_W = 16;
  localparam int TIME_W = 32;
  localparam int AXES = 3;

  localparam logic signed [17:0] HALF_TURN     = 18'sd18000;
  localparam logic signed [17:0] NEG_HALF_TURN = -18'sd18000;
  localparam logic signed [17:0] FULL_TURN     = 18'sd36000;
  localparam logic signed [17:0] TRIPLE_HALF   = 18'sd54000;
  localparam logic signed [17:0] NEG_TRIPLE    = -18'sd54000;
  localparam logic signed [17:0] TWO_TURNS     = 18'sd72000;

  localparam logic [CFG_W-1:0] BAND_RST  = 16'd100;
  localparam logic [CFG_W-1:0] MS_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] COUNT_RST = 16'd10;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_TRACK = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_ZERO  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_STABLE_BAND = 2'd0,
    CFG_MIN_MS      = 2'd1,
    CFG_MIN_COUNT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] zero_ref;
    logic signed [ANG_W-1:0] prev_rel;
    logic signed [ANG_W-1:0] check_ref;
    logic signed [TOT_W-1:0] total;
  } axis_st_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] rel;
    logic signed [TOT_W-1:0] total;
    logic                    in_band;
  } axis_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/otrk_axis.sv =====
// Per-axis datapath: zero offset, wrap, step unwrap with saturating total,
// and the stability band test. Depends on otrk_pkg.
`default_nettype none
module otrk_axis (
  input  wire logic signed [otrk_pkg::ANG_W-1:0] angle,
  input  wire otrk_pkg::axis_st_t                st,
  input  wire logic                              first_pending,
  input  wire logic [otrk_pkg::CFG_W-1:0]        band,
  output otrk_pkg::axis_res_t                    res
);

  logic signed [17:0] diff;
  logic signed [17:0] wrapped;
  logic signed [16:0] step;
  logic signed [16:0] step_f;
  logic signed [32:0] sum;
  logic signed [31:0] total_acc;
  logic signed [16:0] dc;
  logic signed [16:0] mag;

  always_comb begin
    diff = 18'(angle) - 18'(st.zero_ref);
    wrapped = diff;
    if (diff > otrk_pkg::TRIPLE_HALF) begin
      wrapped = diff - otrk_pkg::TWO_TURNS;
    end else if (diff > otrk_pkg::HALF_TURN) begin
      wrapped = diff - otrk_pkg::FULL_TURN;
    end else if (diff < otrk_pkg::NEG_TRIPLE) begin
      wrapped = diff + otrk_pkg::TWO_TURNS;
    end else if (diff < otrk_pkg::NEG_HALF_TURN) begin
      wrapped = diff + otrk_pkg::FULL_TURN;
    end

    step = 17'(wrapped) - 17'(st.prev_rel);
    step_f = step;
    if (18'(step) > otrk_pkg::HALF_TURN) begin
      step_f = step - 17'(otrk_pkg::FULL_TURN);
    end else if (18'(step) < otrk_pkg::NEG_HALF_TURN) begin
      step_f = step + 17'(otrk_pkg::FULL_TURN);
    end

    sum = 33'(st.total) + 33'(step_f);
    if (sum[32] != sum[31]) begin
      total_acc = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      total_acc = sum[31:0];
    end

    dc = 17'(angle) - 17'(st.check_ref);
    mag = (dc < 17'sd0) ? -dc : dc;

    res.rel = wrapped[15:0];
    res.total = first_pending ? 32'(wrapped) : total_acc;
    res.in_band = ($unsigned(mag) <= {1'b0, band});
  end

endmodule
`default_nettype wire

// ===== rtl/core/orientation_zero_unwrap_tracker_top.sv =====
// Orientation zero-reference and multi-turn unwrap tracker, top level.
// An input beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless out_ready holds it off; the tracker state
// updates in the same cycle that an item moves into the result register.
// Reset (rst_n low, synchronous) restores the register defaults and clears all
// tracking and stability state. Depends on otrk_pkg and otrk_axis.
`default_nettype none
module orientation_zero_unwrap_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic signed [15:0] in_yaw_in,
  input  wire logic signed [15:0] in_pitch_in,
  input  wire logic signed [15:0] in_roll_in,
  input  wire logic [31:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_yaw_rel,
  output logic signed [15:0] out_pitch_rel,
  output logic signed [15:0] out_roll_rel,
  output logic signed [31:0] out_yaw_total,
  output logic signed [31:0] out_pitch_total,
  output logic signed [31:0] out_roll_total,
  output logic             out_stable_now,
  output logic             out_calibrated
);

  localparam int AXES = otrk_pkg::AXES;

  logic [15:0] band_r, min_ms_r, min_count_r;

  logic                 v1_r;
  otrk_pkg::cmd_t       cmd_r;
  logic signed [15:0]   ang_r [AXES];
  logic [31:0]          time_r;
  logic                 advance;

  logic signed [15:0] zero_ref_r [AXES], zero_ref_nxt [AXES];
  logic signed [15:0] prev_rel_r [AXES], prev_rel_nxt [AXES];
  logic signed [15:0] rel_r [AXES], rel_nxt [AXES];
  logic signed [31:0] total_r [AXES], total_nxt [AXES];
  logic signed [15:0] check_ref_r [AXES], check_ref_nxt [AXES];
  logic               first_pending_r, first_pending_nxt;
  logic               have_zero_r, have_zero_nxt;
  logic [15:0]        check_count_r, check_count_nxt;
  logic [31:0]        check_start_r, check_start_nxt;
  logic               captured;

  otrk_pkg::axis_res_t ax_res [AXES];
  logic [15:0] count_inc;
  logic [31:0] elapsed;
  logic        all_band;

  logic             vo_r;
  logic signed [15:0] o_rel_r [AXES];
  logic signed [31:0] o_total_r [AXES];
  logic             o_stable_r, o_cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r      <= otrk_pkg::BAND_RST;
      min_ms_r    <= otrk_pkg::MS_RST;
      min_count_r <= otrk_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (otrk_pkg::cfg_idx_t'(cfg_index))
        otrk_pkg::CFG_STABLE_BAND: band_r      <= cfg_wdata;
        otrk_pkg::CFG_MIN_MS:      min_ms_r    <= cfg_wdata;
        otrk_pkg::CFG_MIN_COUNT:   min_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = v1_r && (!vo_r || out_ready);
  assign in_ready = !v1_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r    <= otrk_pkg::cmd_t'(in_command);
      ang_r[0] <= in_yaw_in;
      ang_r[1] <= in_pitch_in;
      ang_r[2] <= in_roll_in;
      time_r   <= in_time_ms;
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    otrk_pkg::axis_st_t st;
    assign st.zero_ref  = zero_ref_r[g];
    assign st.prev_rel  = prev_rel_r[g];
    assign st.check_ref = check_ref_r[g];
    assign st.total     = total_r[g];
    otrk_axis u_axis (
      .angle         (ang_r[g]),
      .st            (st),
      .first_pending (first_pending_r),
      .band          (band_r),
      .res           (ax_res[g])
    );
  end

  assign all_band  = ax_res[0].in_band && ax_res[1].in_band && ax_res[2].in_band;
  assign count_inc = (check_count_r == otrk_pkg::COUNT_MAX) ? check_count_r
                                                            : check_count_r + 16'd1;
  assign elapsed   = time_r - check_start_r;

  always_comb begin
    zero_ref_nxt      = zero_ref_r;
    prev_rel_nxt      = prev_rel_r;
    rel_nxt           = rel_r;
    total_nxt         = total_r;
    check_ref_nxt     = check_ref_r;
    first_pending_nxt = first_pending_r;
    have_zero_nxt     = have_zero_r;
    check_count_nxt   = check_count_r;
    check_start_nxt   = check_start_r;
    captured          = 1'b0;
    case (cmd_r)
      otrk_pkg::CMD_TRACK: begin
        for (int i = 0; i < AXES; i++) begin
          rel_nxt[i]      = ax_res[i].rel;
          prev_rel_nxt[i] = ax_res[i].rel;
          total_nxt[i]    = ax_res[i].total;
        end
        first_pending_nxt = 1'b0;
      end
      otrk_pkg::CMD_CHECK: begin
        if (check_count_r == 16'd0) begin
          check_ref_nxt   = ang_r;
          check_count_nxt = 16'd1;
          check_start_nxt = time_r;
        end else if (all_band) begin
          check_count_nxt = count_inc;
          if (elapsed >= 32'(min_ms_r) && count_inc >= min_count_r) begin
            captured          = 1'b1;
            zero_ref_nxt      = ang_r;
            for (int i = 0; i < AXES; i++) total_nxt[i] = 32'sd0;
            have_zero_nxt     = 1'b1;
            first_pending_nxt = 1'b1;
          end
        end else begin
          for (int i = 0; i < AXES; i++) check_ref_nxt[i] = 16'sd0;
          check_count_nxt = 16'd0;
          check_start_nxt = 32'd0;
        end
      end
      otrk_pkg::CMD_ZERO: begin
        zero_ref_nxt      = ang_r;
        for (int i = 0; i < AXES; i++) total_nxt[i] = 32'sd0;
        have_zero_nxt     = 1'b1;
        first_pending_nxt = 1'b1;
      end
      default: begin
        for (int i = 0; i < AXES; i++) begin
          zero_ref_nxt[i]  = 16'sd0;
          total_nxt[i]     = 32'sd0;
          check_ref_nxt[i] = 16'sd0;
        end
        have_zero_nxt     = 1'b0;
        first_pending_nxt = 1'b1;
        check_count_nxt   = 16'd0;
        check_start_nxt   = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        zero_ref_r[i]  <= 16'sd0;
        prev_rel_r[i]  <= 16'sd0;
        rel_r[i]       <= 16'sd0;
        total_r[i]     <= 32'sd0;
        check_ref_r[i] <= 16'sd0;
      end
      first_pending_r <= 1'b1;
      have_zero_r     <= 1'b0;
      check_count_r   <= 16'd0;
      check_start_r   <= 32'd0;
    end else if (advance) begin
      zero_ref_r      <= zero_ref_nxt;
      prev_rel_r      <= prev_rel_nxt;
      rel_r           <= rel_nxt;
      total_r         <= total_nxt;
      check_ref_r     <= check_ref_nxt;
      first_pending_r <= first_pending_nxt;
      have_zero_r     <= have_zero_nxt;
      check_count_r   <= check_count_nxt;
      check_start_r   <= check_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (advance) begin
      vo_r <= 1'b1;
    end else if (out_ready) begin
      vo_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_rel_r    <= rel_nxt;
      o_total_r  <= total_nxt;
      o_stable_r <= captured;
      o_cal_r    <= have_zero_nxt;
    end
  end

  assign out_valid       = vo_r;
  assign out_yaw_rel     = o_rel_r[0];
  assign out_pitch_rel   = o_rel_r[1];
  assign out_roll_rel    = o_rel_r[2];
  assign out_yaw_total   = o_total_r[0];
  assign out_pitch_total = o_total_r[1];
  assign out_roll_total  = o_total_r[2];
  assign out_stable_now  = o_stable_r;
  assign out_calibrated  = o_cal_r;

  a_stable_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stable_now |-> out_calibrated)
    else $error("zero capture reported without calibration");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r == otrk_pkg::CMD_RESET |=>
      out_valid && !out_calibrated && out_yaw_total == 32'sd0 &&
      out_pitch_total == 32'sd0 && out_roll_total == 32'sd0)
    else $error("reset command left state behind");

  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_yaw_rel <= 16'sd18000 && out_yaw_rel >= -16'sd18000 &&
      out_roll_rel <= 16'sd18000 && out_roll_rel >= -16'sd18000)
    else $error("wrapped angle out of range");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for orientation_zero_unwrap_tracker_top: drives sample and config beats, predicts
// every result beat in a scoreboard class and checks it field by field.
// Depends on otrk_pkg and the tracker RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    LIMIT   = 4_000_000;
  localparam longint TOT_MAX = 64'sd2147483647;
  localparam longint TOT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] yaw_rel;
    logic signed [15:0] pitch_rel;
    logic signed [15:0] roll_rel;
    logic signed [31:0] yaw_total;
    logic signed [31:0] pitch_total;
    logic signed [31:0] roll_total;
    logic               stable_now;
    logic               calibrated;
  } pose_t;

  class orient_scoreboard;
    int unsigned band, min_ms, min_count;
    int          zero_ref[3], prev_rel[3], rel_angle[3], total[3], check_ref[3], axis_in[3];
    bit          first_pending, have_zero;
    int unsigned check_count;
    logic [31:0] check_start;
    pose_t       expected_poses[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      band = otrk_pkg::BAND_RST;
      min_ms = otrk_pkg::MS_RST;
      min_count = otrk_pkg::COUNT_RST;
      for (int i = 0; i < 3; i++) begin
        zero_ref[i] = 0;
        prev_rel[i] = 0;
        rel_angle[i] = 0;
        total[i] = 0;
      end
      first_pending = 1'b1;
      have_zero = 1'b0;
      clear_check();
    endfunction

    function void clear_check();
      for (int i = 0; i < 3; i++) check_ref[i] = 0;
      check_count = 0;
      check_start = '0;
    endfunction

    function void take_zero();
      for (int i = 0; i < 3; i++) begin
        zero_ref[i] = axis_in[i];
        total[i] = 0;
      end
      have_zero = 1'b1;
      first_pending = 1'b1;
    endfunction

    function void write_reg(otrk_pkg::cfg_idx_t idx, logic [15:0] v);
      case (idx)
        otrk_pkg::CFG_STABLE_BAND: band = v;
        otrk_pkg::CFG_MIN_MS:      min_ms = v;
        otrk_pkg::CFG_MIN_COUNT:   min_count = v;
        default: ;
      endcase
    endfunction

    function void note_sample(otrk_pkg::cmd_t cmd, logic signed [15:0] yaw,
                              logic signed [15:0] pitch, logic signed [15:0] roll,
                              logic [31:0] now);
      int          r, d;
      longint      s;
      bit          stable, captured;
      logic [31:0] elapsed;
      pose_t       p;
      axis_in[0] = int'(yaw);
      axis_in[1] = int'(pitch);
      axis_in[2] = int'(roll);
      captured = 1'b0;
      case (cmd)
        otrk_pkg::CMD_TRACK: begin
          for (int i = 0; i < 3; i++) begin
            r = axis_in[i] - zero_ref[i];
            while (r > otrk_pkg::HALF_TURN) r -= otrk_pkg::FULL_TURN;
            while (r < otrk_pkg::NEG_HALF_TURN) r += otrk_pkg::FULL_TURN;
            if (first_pending) begin
              total[i] = r;
            end else begin
              d = r - prev_rel[i];
              if (d > otrk_pkg::HALF_TURN) d -= otrk_pkg::FULL_TURN;
              else if (d < otrk_pkg::NEG_HALF_TURN) d += otrk_pkg::FULL_TURN;
              s = longint'(total[i]) + d;
              if (s > TOT_MAX) s = TOT_MAX;
              if (s < TOT_MIN) s = TOT_MIN;
              total[i] = int'(s);
            end
            prev_rel[i] = r;
            rel_angle[i] = r;
          end
          first_pending = 1'b0;
        end
        otrk_pkg::CMD_CHECK: begin
          if (check_count == 0) begin
            for (int i = 0; i < 3; i++) check_ref[i] = axis_in[i];
            check_count = 1;
            check_start = now;
          end else begin
            stable = 1'b1;
            for (int i = 0; i < 3; i++) begin
              d = axis_in[i] - check_ref[i];
              if (d < 0) d = -d;
              if (d > int'(band)) stable = 1'b0;
            end
            if (stable) begin
              if (check_count < otrk_pkg::COUNT_MAX) check_count++;
              elapsed = now - check_start;
              if (elapsed >= min_ms && check_count >= min_count) begin
                take_zero();
                captured = 1'b1;
              end
            end else begin
              clear_check();
            end
          end
        end
        otrk_pkg::CMD_ZERO: take_zero();
        default: begin
          for (int i = 0; i < 3; i++) begin
            zero_ref[i] = 0;
            total[i] = 0;
          end
          have_zero = 1'b0;
          first_pending = 1'b1;
          clear_check();
        end
      endcase
      p.yaw_rel = 16'(rel_angle[0]);
      p.pitch_rel = 16'(rel_angle[1]);
      p.roll_rel = 16'(rel_angle[2]);
      p.yaw_total = total[0];
      p.pitch_total = total[1];
      p.roll_total = total[2];
      p.stable_now = captured;
      p.calibrated = have_zero;
      expected_poses.push_back(p);
    endfunction

    function void match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (expected_poses.size() == 0) begin
        $error("result beat with no pose expected");
        mismatches++;
        return;
      end
      want = expected_poses.pop_front();
      match_field("yaw_rel", $signed(want.yaw_rel), $signed(got.yaw_rel));
      match_field("pitch_rel", $signed(want.pitch_rel), $signed(got.pitch_rel));
      match_field("roll_rel", $signed(want.roll_rel), $signed(got.roll_rel));
      match_field("yaw_total", want.yaw_total, got.yaw_total);
      match_field("pitch_total", want.pitch_total, got.pitch_total);
      match_field("roll_total", want.roll_total, got.roll_total);
      match_field("stable_now", {31'd0, want.stable_now}, {31'd0, got.stable_now});
      match_field("calibrated", {31'd0, want.calibrated}, {31'd0, got.calibrated});
    endfunction

    function int unsigned pending();
      return expected_poses.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_command;
  logic signed [15:0] in_yaw_in, in_pitch_in, in_roll_in;
  logic [31:0]        in_time_ms;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_yaw_rel, out_pitch_rel, out_roll_rel;
  logic signed [31:0] out_yaw_total, out_pitch_total, out_roll_total;
  logic               out_stable_now, out_calibrated;

  orient_scoreboard sb;
  bit               pace_on = 1'b1;
  int unsigned      cycle_count = 0;

  orientation_zero_unwrap_tracker_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_yaw_in(in_yaw_in), .in_pitch_in(in_pitch_in), .in_roll_in(in_roll_in),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_yaw_rel(out_yaw_rel), .out_pitch_rel(out_pitch_rel), .out_roll_rel(out_roll_rel),
    .out_yaw_total(out_yaw_total), .out_pitch_total(out_pitch_total),
    .out_roll_total(out_roll_total),
    .out_stable_now(out_stable_now), .out_calibrated(out_calibrated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int rand_angle();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 36000)) - 18000;
  endfunction

  task automatic send_sample(otrk_pkg::cmd_t cmd, logic signed [15:0] yaw,
                             logic signed [15:0] pitch, logic signed [15:0] roll,
                             logic [31:0] now);
    int gap;
    gap = pace_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_yaw_in <= yaw;
    in_pitch_in <= pitch;
    in_roll_in <= roll;
    in_time_ms <= now;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_sample(cmd, yaw, pitch, roll, now);
  endtask

  // hold the sender until every pose is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(otrk_pkg::cfg_idx_t idx, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v[15:0]);
  endtask

  task automatic apply_config(int unsigned band, int unsigned ms, int unsigned count);
    drain();
    write_reg(otrk_pkg::CFG_STABLE_BAND, band);
    write_reg(otrk_pkg::CFG_MIN_MS, ms);
    write_reg(otrk_pkg::CFG_MIN_COUNT, count);
  endtask

  task automatic random_run(int beats);
    int          sent, kind, len, i, k, step, span, jb, jit;
    int          p[3];
    int          q[3];
    logic [31:0] t;
    sent = 0;
    while (sent < beats) begin
      kind = $urandom_range(0, 99);
      pace_on = ($urandom_range(0, 4) != 0);
      if (kind < 35) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < 3; k++) p[k] = rand_angle();
        t = $urandom;
        for (i = 0; i < len; i++) begin
          for (k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              p[k] = rand_angle();
            end else begin
              step = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 36000)) - 18000
                                                 : int'($urandom_range(0, 2000)) - 1000;
              p[k] += step;
              if (p[k] > 18000) p[k] -= 36000;
              else if (p[k] < -18000) p[k] += 36000;
            end
          end
          send_sample(otrk_pkg::CMD_TRACK, 16'(p[0]), 16'(p[1]), 16'(p[2]), t);
          t += $urandom_range(1, 50);
          sent++;
        end
      end else if (kind < 70) begin
        jb = (sb.band > 3000) ? 3000 : int'(sb.band);
        len = ((sb.min_count > 25) ? 25 : int'(sb.min_count)) + $urandom_range(1, 4);
        span = int'(sb.min_ms) / len;
        for (k = 0; k < 3; k++) p[k] = rand_angle();
        t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
        for (i = 0; i < len; i++) begin
          for (k = 0; k < 3; k++) begin
            if ($urandom_range(0, 11) == 0) begin
              jit = int'(sb.band) + 1 + int'($urandom_range(0, 20));
              if ($urandom_range(0, 1) == 1) jit = -jit;
            end else begin
              jit = int'($urandom_range(0, 2 * jb)) - jb;
            end
            q[k] = p[k] + jit;
          end
          send_sample(otrk_pkg::CMD_CHECK, 16'(q[0]), 16'(q[1]), 16'(q[2]), t);
          t += $urandom_range(0, 2 * span + 1);
          sent++;
        end
      end else if (kind < 80) begin
        send_sample(otrk_pkg::CMD_ZERO, 16'(rand_angle()), 16'(rand_angle()),
                    16'(rand_angle()), $urandom);
        sent++;
      end else if (kind < 86) begin
        send_sample(otrk_pkg::CMD_RESET, 16'(rand_angle()), 16'(rand_angle()),
                    16'(rand_angle()), $urandom);
        sent++;
      end else if (kind < 88) begin
        drain();
      end else begin
        send_sample(otrk_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    16'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin : result_sink
    pose_t got;
    int    stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pace_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.yaw_rel = out_yaw_rel;
      got.pitch_rel = out_pitch_rel;
      got.roll_rel = out_roll_rel;
      got.yaw_total = out_yaw_total;
      got.pitch_total = out_pitch_total;
      got.roll_total = out_roll_total;
      got.stable_now = out_stable_now;
      got.calibrated = out_calibrated;
      sb.check_pose(got);
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    int          i, sgn;
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_command <= '0;
    in_yaw_in <= '0;
    in_pitch_in <= '0;
    in_roll_in <= '0;
    in_time_ms <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(otrk_pkg::CMD_TRACK, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    send_sample(otrk_pkg::CMD_TRACK, 16'sh7FFF, -16'sh8000, 16'sd18000, 32'd1);
    send_sample(otrk_pkg::CMD_TRACK, -16'sd18000, 16'sd18001, -16'sd18001, 32'd2);
    send_sample(otrk_pkg::CMD_TRACK, 16'sd18000, -16'sd18000, 16'sd0, 32'd3);
    send_sample(otrk_pkg::CMD_ZERO, -16'sd18000, 16'sd18000, 16'sh7FFF, 32'd4);
    send_sample(otrk_pkg::CMD_TRACK, 16'sd18000, -16'sd18000, -16'sh8000, 32'd5);
    send_sample(otrk_pkg::CMD_TRACK, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
    send_sample(otrk_pkg::CMD_CHECK, 16'sd1000, -16'sd1000, 16'sd500, 32'hFFFF_FF00);
    send_sample(otrk_pkg::CMD_CHECK, 16'sd1100, -16'sd1100, 16'sd400, 32'hFFFF_FF64);
    send_sample(otrk_pkg::CMD_CHECK, 16'sd1101, -16'sd1000, 16'sd500, 32'hFFFF_FFC8);
    send_sample(otrk_pkg::CMD_RESET, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    t = 32'hFFFF_FE00;
    for (i = 0; i < 11; i++) begin
      sgn = (i % 2 == 0) ? 100 : -100;
      if (i == 0) sgn = 0;
      send_sample(otrk_pkg::CMD_CHECK, 16'(-5 + sgn), 16'(5 - sgn), 16'(sgn), t);
      t += 120;
    end
    send_sample(otrk_pkg::CMD_TRACK, 16'sd100, 16'sd200, -16'sd300, 32'd7);
    send_sample(otrk_pkg::CMD_RESET, -16'sd1, 16'sd1, 16'sd0, 32'd8);
    drain();

    apply_config(0, 0, 0);
    random_run(200);
    apply_config(36000, 65535, 65535);
    random_run(150);
    apply_config(50, 30, 4);
    random_run(300);
    apply_config(otrk_pkg::BAND_RST, otrk_pkg::MS_RST, otrk_pkg::COUNT_RST);
    random_run(250);
    apply_config($urandom_range(0, 36000), $urandom_range(0, 400), $urandom_range(0, 20));
    random_run(300);

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
